>>> design/gyro_angle_integrator_settle_detect_unit_defines.svh
// Assertion macros for the gyro integrator RTL.
`ifndef GYRO_ANGLE_INTEGRATOR_SETTLE_DETECT_UNIT_DEFINES_SVH
`define GYRO_ANGLE_INTEGRATOR_SETTLE_DETECT_UNIT_DEFINES_SVH
`ifndef SYNTH
`define GAIS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gais check failed");
`define GAIS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gais check failed");
`else
`define GAIS_ASSERT_IMP(lbl, ante, cons)
`define GAIS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> design/gais_pkg.sv
// Shared types and constants of the gyro angle integrator.
package gais_pkg;

	localparam int NUM_AXES   = 3;
	localparam int OUT_W      = 40;
	localparam int FRAC_W     = 16;
	localparam int SCALE_W    = 16;
	localparam int STEP_W     = 16;
	localparam int THR_W      = 31;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;

	localparam logic [SCALE_W-1:0] RATE_SCALE_RST = SCALE_W'(4920);
	localparam logic [STEP_W-1:0]  TIME_STEP_RST  = STEP_W'(1376);
	localparam logic [THR_W-1:0]   RATE_THR_RST   = THR_W'(655360);
	localparam logic [THR_W-1:0]   ANGLE_THR_RST  = THR_W'(655360);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RATE_SCALE = 2'd0,
		REG_TIME_STEP  = 2'd1,
		REG_RATE_THR   = 2'd2,
		REG_ANGLE_THR  = 2'd3
	} cfg_reg_t;

	// stage advance and clear strobes from the sequencer to every lane
	typedef struct packed {
		logic adv_s1;
		logic adv_s2;
		logic adv_s3;
		logic adv_s4;
		logic clr;
	} lane_ctl_t;

	// what one lane found about its axis
	typedef struct packed {
		logic still;
		logic moved;
	} lane_flag_t;

endpackage

>>> design/gais_lane.sv
// One axis lane: rate scale, time step, saturating accumulate, threshold checks.
module gais_lane #(
	parameter int SW = 16,
	parameter int AW = 40
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  gais_pkg::lane_ctl_t              ctl,
	input  logic [SW-1:0]                    raw,
	input  logic [gais_pkg::SCALE_W-1:0]     rate_scale,
	input  logic [gais_pkg::STEP_W-1:0]      time_step,
	input  logic [gais_pkg::THR_W-1:0]       rate_thr,
	input  logic [gais_pkg::THR_W-1:0]       angle_thr,
	output logic signed [AW-1:0]             acc,
	output gais_pkg::lane_flag_t             flag
);

	localparam int RMAG_W = SW + gais_pkg::SCALE_W;
	localparam int PROD_W = RMAG_W + gais_pkg::STEP_W;
	localparam int IMAG_W = PROD_W - gais_pkg::FRAC_W;
	localparam int INC_W  = IMAG_W + 1;
	localparam int SUM_W  = ((AW > INC_W) ? AW : INC_W) + 1;
	localparam int RCMP_W = (RMAG_W > gais_pkg::THR_W) ? RMAG_W : gais_pkg::THR_W;
	localparam int ACMP_W = (AW > gais_pkg::THR_W) ? AW : gais_pkg::THR_W;

	localparam logic [PROD_W-1:0] RND = PROD_W'(1) << (gais_pkg::FRAC_W - 1);
	localparam logic signed [SUM_W-1:0] ACC_HI = {{(SUM_W-AW+1){1'b0}}, {(AW-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] ACC_LO = {{(SUM_W-AW+1){1'b1}}, {(AW-1){1'b0}}};

	logic [SW-1:0]            raw_mag;
	logic [RMAG_W-1:0]        rmag_s1;
	logic                     neg_s1;
	logic [PROD_W-1:0]        prod;
	logic [IMAG_W-1:0]        imag_s2;
	logic                     neg_s2;
	logic                     still_s2;
	logic signed [INC_W-1:0]  inc;
	logic signed [SUM_W-1:0]  sum;
	logic signed [AW-1:0]     sat;
	logic signed [AW-1:0]     acc_q;
	logic [AW-1:0]            acc_mag;
	gais_pkg::lane_flag_t     flag_s4;

	assign raw_mag = raw[SW-1] ? (~raw + SW'(1)) : raw;
	assign prod    = PROD_W'(rmag_s1) * PROD_W'(time_step) + RND;
	assign inc     = neg_s2 ? -$signed({1'b0, imag_s2}) : $signed({1'b0, imag_s2});
	assign sum     = SUM_W'(acc_q) + SUM_W'(inc);
	assign acc_mag = acc_q[AW-1] ? (~acc_q + AW'(1)) : acc_q;

	always_comb begin
		if (sum > ACC_HI) begin
			sat = AW'(ACC_HI);
		end else if (sum < ACC_LO) begin
			sat = AW'(ACC_LO);
		end else begin
			sat = AW'(sum);
		end
	end

	// rate magnitude, then angle increment magnitude with round half up, rate check and flag register
	always_ff @(posedge clk) begin
		if (ctl.adv_s1) begin
			rmag_s1 <= RMAG_W'(raw_mag) * RMAG_W'(rate_scale);
			neg_s1  <= raw[SW-1];
		end
		if (ctl.adv_s2) begin
			imag_s2  <= prod[PROD_W-1:gais_pkg::FRAC_W];
			neg_s2   <= neg_s1;
			still_s2 <= RCMP_W'(rmag_s1) < RCMP_W'(rate_thr);
		end
		if (ctl.adv_s4) begin
			flag_s4.still <= still_s2;
			flag_s4.moved <= ACMP_W'(acc_mag) > ACMP_W'(angle_thr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.adv_s3) begin
			acc_q <= sat;
		end
	end

	assign acc  = acc_q;
	assign flag = flag_s4;

endmodule

>>> design/gais_merge.sv
// Sequencer and merge stage: combines lane flags and holds the result register.
`include "gyro_angle_integrator_settle_detect_unit_defines.svh"
module gais_merge #(
	parameter int AW = 40
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              in_accept,
	input  gais_pkg::lane_flag_t [gais_pkg::NUM_AXES-1:0]     flags,
	input  logic [gais_pkg::NUM_AXES-1:0][AW-1:0]             accs,
	input  logic                                              out_stall,
	output gais_pkg::lane_ctl_t                               ctl,
	output logic                                              busy,
	output logic                                              out_valid,
	output logic [gais_pkg::NUM_AXES-1:0][gais_pkg::OUT_W-1:0] angles
);

	logic vld_s1;
	logic vld_s2;
	logic vld_s3;
	logic vld_s4;
	logic emit_s4;
	logic out_free;
	logic load;
	logic retire;
	logic out_valid_q;
	logic [gais_pkg::NUM_AXES-1:0][gais_pkg::OUT_W-1:0] angles_q;

	always_comb begin
		emit_s4 = 1'b1;
		for (int a = 0; a < gais_pkg::NUM_AXES; a++) begin
			emit_s4 = emit_s4 & flags[a].still;
		end
		emit_s4 = emit_s4 & (flags[0].moved | flags[1].moved | flags[2].moved);
	end

	assign out_free = !out_valid_q || !out_stall;
	assign load     = vld_s4 && emit_s4 && out_free;
	assign retire   = vld_s4 && (!emit_s4 || out_free);
	assign busy     = vld_s1 | vld_s2 | vld_s3 | vld_s4;

	assign ctl.adv_s1 = in_accept;
	assign ctl.adv_s2 = vld_s1;
	assign ctl.adv_s3 = vld_s2;
	assign ctl.adv_s4 = vld_s3;
	assign ctl.clr    = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= in_accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			if (vld_s3) begin
				vld_s4 <= 1'b1;
			end else if (retire) begin
				vld_s4 <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int a = 0; a < gais_pkg::NUM_AXES; a++) begin
				angles_q[a] <= gais_pkg::OUT_W'($signed(accs[a]));
			end
		end
	end

	assign out_valid = out_valid_q;
	assign angles    = angles_q;

	`GAIS_ASSERT_IMP(a_one_in_flight, 1'b1, $onehot0({vld_s1, vld_s2, vld_s3, vld_s4}))
	`GAIS_ASSERT_IMP(a_no_accept_busy, in_accept, !busy)
	`GAIS_ASSERT_NXT(a_load_shows, load, out_valid_q)
	`GAIS_ASSERT_NXT(a_quiet_retires, vld_s4 && !emit_s4, !vld_s4)
	`GAIS_ASSERT_IMP(a_clr_alone, ctl.clr, !ctl.adv_s3)

endmodule

>>> design/gyro_angle_integrator_settle_detect_unit.sv
// Top level of the gyro angle integrator with settle detection.
//
//  channel  direction  handshake               payload
//  in       sink       in_valid / in_stall     raw_x, raw_y, raw_z
//  out      source     out_valid / out_stall   angle_x, angle_y, angle_z
//  cfg      sink       cfg_we                  cfg_idx, cfg_wdata
//
// One word is in flight at a time. A word is accepted, then runs through
// rate multiply, step multiply with rounding, accumulator add and threshold
// checks, and retires from the last stage; the next word can be taken in the
// cycle after that, so the block takes no new word before the last retires,
// set by the per-axis lane pipeline and the accumulator feedback it closes.
// A result stalled at the output holds the retiring word; once the result
// register is loaded, a new word is accepted even while the result waits.
// Reset clears the accumulators and loads the register defaults.
module gyro_angle_integrator_settle_detect_unit #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int ACC_WIDTH    = 40
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]      raw_x,
	input  logic signed [SAMPLE_WIDTH-1:0]      raw_y,
	input  logic signed [SAMPLE_WIDTH-1:0]      raw_z,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [gais_pkg::OUT_W-1:0]   angle_x,
	output logic signed [gais_pkg::OUT_W-1:0]   angle_y,
	output logic signed [gais_pkg::OUT_W-1:0]   angle_z,
	input  logic                                cfg_we,
	input  logic [gais_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [gais_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	logic [gais_pkg::SCALE_W-1:0] rate_scale_q;
	logic [gais_pkg::STEP_W-1:0]  time_step_q;
	logic [gais_pkg::THR_W-1:0]   rate_thr_q;
	logic [gais_pkg::THR_W-1:0]   angle_thr_q;

	logic                                                       in_accept;
	logic                                                       busy;
	gais_pkg::lane_ctl_t                                        ctl;
	logic [gais_pkg::NUM_AXES-1:0][SAMPLE_WIDTH-1:0]            raws;
	logic [gais_pkg::NUM_AXES-1:0][ACC_WIDTH-1:0]               accs;
	gais_pkg::lane_flag_t [gais_pkg::NUM_AXES-1:0]              flags;
	logic [gais_pkg::NUM_AXES-1:0][gais_pkg::OUT_W-1:0]         angles;

	// take a word only when no earlier word is still in the lanes
	assign in_stall  = busy;
	assign in_accept = in_valid && !busy;

	assign raws[0] = raw_x;
	assign raws[1] = raw_y;
	assign raws[2] = raw_z;

	// register writes; the user must change configuration only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_scale_q <= gais_pkg::RATE_SCALE_RST;
			time_step_q  <= gais_pkg::TIME_STEP_RST;
			rate_thr_q   <= gais_pkg::RATE_THR_RST;
			angle_thr_q  <= gais_pkg::ANGLE_THR_RST;
		end else if (cfg_we) begin
			case (gais_pkg::cfg_reg_t'(cfg_idx))
				gais_pkg::REG_RATE_SCALE: begin
					rate_scale_q <= cfg_wdata[gais_pkg::SCALE_W-1:0];
				end
				gais_pkg::REG_TIME_STEP: begin
					time_step_q <= cfg_wdata[gais_pkg::STEP_W-1:0];
				end
				gais_pkg::REG_RATE_THR: begin
					rate_thr_q <= cfg_wdata[gais_pkg::THR_W-1:0];
				end
				gais_pkg::REG_ANGLE_THR: begin
					angle_thr_q <= cfg_wdata[gais_pkg::THR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// one lane per axis, all advanced by the same strobes
	for (genvar a = 0; a < gais_pkg::NUM_AXES; a++) begin : g_lane
		gais_lane #(
			.SW (SAMPLE_WIDTH),
			.AW (ACC_WIDTH)
		) u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.raw        (raws[a]),
			.rate_scale (rate_scale_q),
			.time_step  (time_step_q),
			.rate_thr   (rate_thr_q),
			.angle_thr  (angle_thr_q),
			.acc        (accs[a]),
			.flag       (flags[a])
		);
	end

	// merge: all still and any moved emits the angles and clears the lanes
	gais_merge #(
		.AW (ACC_WIDTH)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.flags     (flags),
		.accs      (accs),
		.out_stall (out_stall),
		.ctl       (ctl),
		.busy      (busy),
		.out_valid (out_valid),
		.angles    (angles)
	);

	assign angle_x = angles[0];
	assign angle_y = angles[1];
	assign angle_z = angles[2];

endmodule

>>> dv/gyro_angle_integrator_settle_detect_unit_tb.sv
// Self-checking testbench of the gyro angle integrator with settle detection.
module gyro_angle_integrator_settle_detect_unit_tb;
	import gais_pkg::*;

	localparam int SAMPLE_W = 16;
	localparam longint ACC_MAX = 64'sh0000_007F_FFFF_FFFF;
	localparam longint ACC_MIN = -ACC_MAX - 1;
	localparam logic [THR_W-1:0] THR_MAX = {THR_W{1'b1}};
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 10;

	typedef struct packed {
		logic [SAMPLE_W-1:0] x;
		logic [SAMPLE_W-1:0] y;
		logic [SAMPLE_W-1:0] z;
	} gyro_sample_t;

	typedef struct packed {
		logic [OUT_W-1:0] x;
		logic [OUT_W-1:0] y;
		logic [OUT_W-1:0] z;
	} angle_triplet_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [SAMPLE_W-1:0] raw_x = '0;
	logic signed [SAMPLE_W-1:0] raw_y = '0;
	logic signed [SAMPLE_W-1:0] raw_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [OUT_W-1:0] angle_x;
	logic signed [OUT_W-1:0] angle_y;
	logic signed [OUT_W-1:0] angle_z;
	logic cfg_we = 1'b0;
	cfg_reg_t cfg_idx = REG_RATE_SCALE;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// Predictor state: register copies and the three angle accumulators.
	logic [SCALE_W-1:0] scale_q = RATE_SCALE_RST;
	logic [STEP_W-1:0] step_q = TIME_STEP_RST;
	logic [THR_W-1:0] rate_lim = RATE_THR_RST;
	logic [THR_W-1:0] angle_lim = ANGLE_THR_RST;
	longint angle_acc [NUM_AXES] = '{0, 0, 0};

	gyro_sample_t pending_samples_q[$];
	angle_triplet_t settled_angles_q[$];
	int words_issued = 0;
	int words_taken = 0;
	bit fail_seen = 1'b0;

	// Idle odds per side, in percent; the stimulus process retunes them per phase.
	int in_gap_pct = 36;
	int out_gap_pct = 36;
	int pressure_req = 0;
	int pressure_ack = 0;
	int hold_left = 0;

	gyro_angle_integrator_settle_detect_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.raw_x     (raw_x),
		.raw_y     (raw_y),
		.raw_z     (raw_z),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.angle_x   (angle_x),
		.angle_y   (angle_y),
		.angle_z   (angle_z),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run one accepted sample through the integrator and record any settled angles.
	function automatic void integrate_sample(input gyro_sample_t s);
		longint raw [NUM_AXES];
		longint unsigned rmag;
		longint unsigned imag;
		longint unsigned amag;
		longint inc;
		longint sum;
		logic still;
		logic moved;
		angle_triplet_t res;
		raw[0] = $signed(s.x);
		raw[1] = $signed(s.y);
		raw[2] = $signed(s.z);
		still = 1'b1;
		moved = 1'b0;
		for (int a = 0; a < NUM_AXES; a++) begin
			rmag = (raw[a] < 0) ? -raw[a] : raw[a];
			rmag = rmag * scale_q;
			// Round to nearest; the magnitude path makes ties go away from zero.
			imag = (rmag * step_q + 64'd32768) >> FRAC_W;
			inc = (raw[a] < 0) ? -longint'(imag) : longint'(imag);
			sum = angle_acc[a] + inc;
			if (sum > ACC_MAX) begin
				sum = ACC_MAX;
			end else if (sum < ACC_MIN) begin
				sum = ACC_MIN;
			end
			angle_acc[a] = sum;
			if (!(rmag < rate_lim)) begin
				still = 1'b0;
			end
		end
		for (int a = 0; a < NUM_AXES; a++) begin
			amag = (angle_acc[a] < 0) ? -angle_acc[a] : angle_acc[a];
			if (amag > angle_lim) begin
				moved = 1'b1;
			end
		end
		if (still && moved) begin
			res.x = OUT_W'(angle_acc[0]);
			res.y = OUT_W'(angle_acc[1]);
			res.z = OUT_W'(angle_acc[2]);
			settled_angles_q.push_back(res);
			for (int a = 0; a < NUM_AXES; a++) begin
				angle_acc[a] = 0;
			end
		end
	endfunction

	function automatic void compare_angle(input string axis, input logic [OUT_W-1:0] want,
			input logic [OUT_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d got %0d", $time, axis, $signed(want), $signed(got));
			fail_seen = 1'b1;
		end
	endfunction

	// Driver: offer the next queued word once the current one is taken; hold it while stalled.
	always @(posedge clk) begin
		gyro_sample_t s;
		if (arst_n && (!in_valid || !in_stall)) begin
			if (pending_samples_q.size() != 0 && $urandom_range(99) >= in_gap_pct) begin
				s = pending_samples_q.pop_front();
				in_valid <= 1'b1;
				raw_x <= s.x;
				raw_y <= s.y;
				raw_z <= s.z;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: stall at random, or hold off for a long stretch when asked.
	always @(posedge clk) begin
		if (pressure_req != pressure_ack) begin
			pressure_ack <= pressure_req;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < out_gap_pct);
		end
	end

	// Monitor: check each taken result word, then predict from each taken sample word.
	always @(posedge clk) begin
		angle_triplet_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (settled_angles_q.size() == 0) begin
					$display("%0t: unexpected result expected none got x=%0d y=%0d z=%0d",
						$time, angle_x, angle_y, angle_z);
					fail_seen = 1'b1;
				end else begin
					want = settled_angles_q.pop_front();
					compare_angle("angle_x", want.x, angle_x);
					compare_angle("angle_y", want.y, angle_y);
					compare_angle("angle_z", want.z, angle_z);
				end
			end
			if (in_valid && !in_stall) begin
				integrate_sample('{x: raw_x, y: raw_y, z: raw_z});
				words_taken++;
			end
		end
	end

	task automatic queue_sample(input logic [SAMPLE_W-1:0] x, input logic [SAMPLE_W-1:0] y,
			input logic [SAMPLE_W-1:0] z);
		pending_samples_q.push_back('{x: x, y: y, z: z});
		words_issued++;
	endtask

	// Write one register; narrow registers get random junk above their width.
	task automatic program_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		logic [CFG_DATA_W-1:0] wdata;
		wdata = value;
		case (idx)
			REG_RATE_SCALE: begin
				wdata = {CFG_DATA_W'($urandom)} << SCALE_W | CFG_DATA_W'(value[SCALE_W-1:0]);
				scale_q = wdata[SCALE_W-1:0];
			end
			REG_TIME_STEP: begin
				wdata = {CFG_DATA_W'($urandom)} << STEP_W | CFG_DATA_W'(value[STEP_W-1:0]);
				step_q = wdata[STEP_W-1:0];
			end
			REG_RATE_THR: begin
				rate_lim = wdata[THR_W-1:0];
			end
			REG_ANGLE_THR: begin
				angle_lim = wdata[THR_W-1:0];
			end
		endcase
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= wdata;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input logic [SCALE_W-1:0] scale, input logic [STEP_W-1:0] step,
			input logic [THR_W-1:0] rthr, input logic [THR_W-1:0] athr);
		program_reg(REG_RATE_SCALE, CFG_DATA_W'(scale));
		program_reg(REG_TIME_STEP, CFG_DATA_W'(step));
		program_reg(REG_RATE_THR, CFG_DATA_W'(rthr));
		program_reg(REG_ANGLE_THR, CFG_DATA_W'(athr));
	endtask

	// Wait until every word is taken and every result is back, then let the pipe empty.
	task automatic drain_pipeline();
		while (words_taken != words_issued || settled_angles_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_coeff();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// Mostly still samples below the rate limit with random sign; the rest is full range.
	function automatic gyro_sample_t draw_sample(input int unsigned lim);
		logic [SAMPLE_W-1:0] ax [NUM_AXES];
		int mag;
		for (int a = 0; a < NUM_AXES; a++) begin
			if ($urandom_range(99) < 75) begin
				mag = $urandom_range(lim - 1, 0);
				ax[a] = $urandom_range(1) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
			end else begin
				ax[a] = SAMPLE_W'($urandom);
			end
		end
		return '{x: ax[0], y: ax[1], z: ax[2]};
	endfunction

	initial begin
		gyro_sample_t s;
		longint unsigned rthr;
		longint unsigned athr;
		longint unsigned inc_at;
		int unsigned lim;
		logic [15:0] scale;
		logic [15:0] step;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: field extremes and a small still sample.
		queue_sample(16'd0, 16'd0, 16'd0);
		queue_sample(16'h7FFF, 16'h8000, 16'd1);
		queue_sample(16'hFFFF, 16'h8000, 16'h7FFF);
		queue_sample(16'h8000, 16'h7FFF, 16'hFFFF);
		queue_sample(16'd133, -16'sd133, 16'd0);
		drain_pipeline();

		// Unit scale and full step make the increment equal the raw magnitude,
		// so both strict compares can be hit exactly at the threshold.
		set_config(16'd1, 16'hFFFF, 31'd1000, 31'd500);
		queue_sample(16'd0, 16'd0, 16'd0);
		queue_sample(16'd500, 16'd0, 16'd0);
		queue_sample(16'd1, 16'd0, 16'd0);
		queue_sample(16'd1000, 16'd0, 16'd0);
		queue_sample(16'd999, 16'd0, 16'd0);
		queue_sample(16'd0, -16'sd501, 16'd0);
		queue_sample(16'd0, 16'd0, -16'sd500);
		queue_sample(16'd0, 16'd0, -16'sd1);
		drain_pipeline();

		// Zero scale: increments vanish, nothing to emit.
		set_config(16'd0, 16'hFFFF, 31'd1, 31'd0);
		queue_sample(16'h7FFF, 16'h8000, 16'd5);
		queue_sample(16'd0, 16'd0, 16'd0);
		drain_pipeline();

		// Zero step with the largest rate threshold and a zero angle threshold.
		set_config(16'hFFFF, 16'd0, THR_MAX, 31'd0);
		queue_sample(16'h8000, 16'h7FFF, 16'd0);
		drain_pipeline();

		// Zero rate threshold blocks emission; drive x to the top rail, y to the bottom.
		set_config(16'hFFFF, 16'hFFFF, 31'd0, 31'd0);
		repeat (400) begin
			queue_sample(SAMPLE_W'($urandom_range(32767, 24576)),
				SAMPLE_W'(-int'($urandom_range(32768, 24576))), SAMPLE_W'($urandom));
		end
		drain_pipeline();

		// Release the saturated accumulators, then confirm the clear.
		set_config(16'hFFFF, 16'hFFFF, THR_MAX, THR_MAX);
		queue_sample(16'd0, 16'd0, 16'd0);
		queue_sample(16'd0, 16'd0, 16'd0);
		drain_pipeline();

		for (int ph = 0; ph < 12; ph++) begin
			in_gap_pct = 36;
			out_gap_pct = 36;
			scale = pick_coeff();
			step = pick_coeff();
			if (ph == 7) begin
				// Every word is still and any nonzero angle settles; stop the receiver so the block backs up.
				if (scale == 0) scale = 16'd1;
				if (step == 0) step = 16'd1;
				set_config(scale, step, THR_MAX, 31'd0);
				in_gap_pct = 0;
				pressure_req++;
				repeat (100) queue_sample(SAMPLE_W'($urandom), SAMPLE_W'($urandom),
					SAMPLE_W'($urandom));
			end else begin
				lim = $urandom_range(1) ? $urandom_range(512, 1) : $urandom_range(32768, 1);
				rthr = longint'(lim) * scale;
				inc_at = (rthr * step + 64'd32768) >> FRAC_W;
				athr = inc_at * $urandom_range(6, 0);
				if (athr > THR_MAX) athr = THR_MAX;
				set_config(scale, step, THR_W'(rthr), THR_W'(athr));
				if (ph == 3) begin
					// Long stretch with no idling on either side.
					in_gap_pct = 0;
					out_gap_pct = 0;
				end
				repeat (100) begin
					s = draw_sample(lim);
					queue_sample(s.x, s.y, s.z);
				end
			end
			drain_pipeline();
		end

		if (!fail_seen && settled_angles_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> sim.f
+incdir+design
design/gais_pkg.sv
design/gais_lane.sv
design/gais_merge.sv
design/gyro_angle_integrator_settle_detect_unit.sv
dv/gyro_angle_integrator_settle_detect_unit_tb.sv
